@@ sv/srv_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srv_pkg
// Shared types, register codes and fixed-point helpers for the Schroeder
// reverberator: 24-bit Q9.15 words, Q0.16 gains and saturating arithmetic.
// ----------------------------------------------------------------------------
package srv_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int COEF_W    = 17;
    localparam int WORD_W    = 24;
    localparam int SUM_W     = 28;
    localparam int PROD_W    = 42;
    localparam int PTR_W     = 12;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [GAIN_W-1:0]   gain_t;
    typedef logic        [COEF_W-1:0]   coef_t;
    typedef logic signed [WORD_W-1:0]   word_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMB_GAIN   = 2'd0,
        CFG_INPUT_GAIN  = 2'd1,
        CFG_OUTPUT_GAIN = 2'd2
    } cfg_reg_t;

    localparam gain_t COMB_GAIN_RST   = 16'd60293;
    localparam gain_t INPUT_GAIN_RST  = 16'd45875;
    localparam gain_t OUTPUT_GAIN_RST = 16'd52429;

    typedef struct packed {
        logic             active;
        logic [PTR_W-1:0] addr;
    } srv_clr_t;

    typedef struct packed {
        word_t x;
        word_t w;
    } ap_pair_t;

    function automatic sum_t srv_wide(input word_t a);
        sum_t r;
        r = a;
        return r;
    endfunction

    function automatic word_t srv_sat24(input sum_t v);
        word_t r;
        if (v > 28'sd8388607)
            r = 24'sh7fffff;
        else if (v < -28'sd8388608)
            r = 24'sh800000;
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

    function automatic prod_t srv_mul(input word_t a, input coef_t k);
        prod_t ea;
        prod_t ek;
        ea = a;
        ek = $signed({{(PROD_W-COEF_W){1'b0}}, k});
        return ea * ek;
    endfunction

    // round half up, drop 16 fraction bits, saturate
    function automatic word_t srv_gscale(input prod_t p);
        prod_t r;
        prod_t q;
        r = p + 42'sd32768;
        q = r >>> 16;
        return srv_sat24(q[SUM_W-1:0]);
    endfunction

    function automatic sample_t srv_sat16(input word_t v);
        sample_t r;
        if (v > 24'sd32767)
            r = 16'sh7fff;
        else if (v < -24'sd32768)
            r = 16'sh8000;
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/srv_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srv_in_if
// Input sample channel: valid/ready handshake carrying one Q1.15 sample.
// ----------------------------------------------------------------------------
interface srv_in_if;
    import srv_pkg::*;

    logic    valid;
    logic    ready;
    sample_t in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink (input valid, input in_sample, output ready);
endinterface
`default_nettype wire

@@ sv/srv_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srv_out_if
// Output sample channel: valid/ready handshake carrying one Q1.15 sample.
// ----------------------------------------------------------------------------
interface srv_out_if;
    import srv_pkg::*;

    logic    valid;
    logic    ready;
    sample_t out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink (input valid, input out_sample, output ready);
endinterface
`default_nettype wire

@@ sv/schroeder_reverb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// schroeder_reverb
// Four parallel feedback combs, two series allpasses, input and output gain.
// ----------------------------------------------------------------------------
// One sample enters per clock while the block is ready (no back-pressure,
// write-back window or clear sweep holding it off); a nine-stage elastic
// pipeline sits in front of an output register, so bubbles close up and
// input keeps flowing while a result waits. Every delay line is a RAM with
// registered read: all lines are read when a sample is accepted, the combs
// write back in stage 2, the first allpass in stage 3's successor (stage 4)
// and the second allpass in stage 6. With any delay of 6 samples or less, a
// sample is held off until the sample it depends on has been written back,
// so at most (shortest delay) samples are in stages 1 to 6 at once. After
// reset the block zeroes its delay memories, one entry per cycle, over
// addresses 0 to the longest delay and accepts no sample until then;
// configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module schroeder_reverb #(
    parameter int COMB_DELAY_ONE    = 1440,
    parameter int COMB_DELAY_TWO    = 1680,
    parameter int COMB_DELAY_THREE  = 1968,
    parameter int COMB_DELAY_FOUR   = 2112,
    parameter int ALLPASS_DELAY_ONE = 240,
    parameter int ALLPASS_DELAY_TWO = 82
) (
    input  logic                            clk,
    input  logic                            rst_n,
    srv_in_if.sink                          dry,
    srv_out_if.source                       wet,
    input  logic                            cfg_we,
    input  logic [srv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srv_pkg::GAIN_W-1:0]      cfg_wdata
);
    import srv_pkg::*;

    localparam int NSTG  = 9;
    localparam int WIN   = 6;
    localparam int CNT_W = $clog2(WIN + 1);

    localparam int MIN_A = (COMB_DELAY_ONE < COMB_DELAY_TWO) ? COMB_DELAY_ONE : COMB_DELAY_TWO;
    localparam int MIN_B = (COMB_DELAY_THREE < COMB_DELAY_FOUR) ? COMB_DELAY_THREE
                                                                : COMB_DELAY_FOUR;
    localparam int MIN_C = (ALLPASS_DELAY_ONE < ALLPASS_DELAY_TWO) ? ALLPASS_DELAY_ONE
                                                                   : ALLPASS_DELAY_TWO;
    localparam int MIN_D = (MIN_A < MIN_B) ? MIN_A : MIN_B;
    localparam int TMIN  = (MIN_D < MIN_C) ? MIN_D : MIN_C;

    localparam int MAX_A = (COMB_DELAY_ONE > COMB_DELAY_TWO) ? COMB_DELAY_ONE : COMB_DELAY_TWO;
    localparam int MAX_B = (COMB_DELAY_THREE > COMB_DELAY_FOUR) ? COMB_DELAY_THREE
                                                                : COMB_DELAY_FOUR;
    localparam int MAX_C = (ALLPASS_DELAY_ONE > ALLPASS_DELAY_TWO) ? ALLPASS_DELAY_ONE
                                                                   : ALLPASS_DELAY_TWO;
    localparam int MAX_D = (MAX_A > MAX_B) ? MAX_A : MAX_B;
    localparam int TMAX  = (MAX_D > MAX_C) ? MAX_D : MAX_C;

    localparam logic [PTR_W-1:0] TMIN_C   = PTR_W'(TMIN);
    localparam logic [PTR_W-1:0] CLR_LAST = PTR_W'(TMAX);

    localparam int COMB_DEPTH [4] = '{COMB_DELAY_ONE + 1, COMB_DELAY_TWO + 1,
                                      COMB_DELAY_THREE + 1, COMB_DELAY_FOUR + 1};

    // configuration
    gain_t            comb_gain_reg;
    gain_t            input_gain_reg;
    gain_t            output_gain_reg;
    logic [31:0]      gg_prod_reg;
    logic [31:0]      gg_prod_next;
    logic [32:0]      gg_round;
    coef_t            coef_reg;
    coef_t            coef_next;
    coef_t            g_coef;

    // clear sweep
    logic             clr_active_reg;
    logic             clr_active_next;
    logic [PTR_W-1:0] clr_addr_reg;
    logic [PTR_W-1:0] clr_addr_next;
    srv_clr_t         clr_bus;

    // pipeline control
    logic [NSTG:1]    vld_reg;
    logic [NSTG:1]    vld_next;
    logic [NSTG+1:1]  go;
    logic [CNT_W-1:0] win_cnt;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             dry_ready;
    logic             dry_accept;
    logic             wet_deliver;
    logic             comb_we;
    logic             ap1_we;
    logic             ap2_we;

    // line read data
    word_t            comb_rd [4];
    ap_pair_t         ap1_rd;
    ap_pair_t         ap2_rd;
    ap_pair_t         ap1_wr;
    ap_pair_t         ap2_wr;

    // stage payload
    sample_t          s1_reg;
    prod_t            px0_reg;
    prod_t            px0_next;
    prod_t            pcfb_reg [4];
    prod_t            pcfb_next [4];
    prod_t            paw1_reg;
    prod_t            paw1_next;
    prod_t            paw2_reg;
    prod_t            paw2_next;
    word_t            ax1_reg;
    word_t            ax2_reg;
    word_t            x0;
    word_t            cw_reg [4];
    word_t            cw_next [4];
    word_t            wa1_3_reg;
    word_t            wa1_3_next;
    word_t            wa2_3_reg;
    word_t            wa2_3_next;
    word_t            sum_reg;
    word_t            sum_next;
    word_t            wa1_4_reg;
    word_t            wa2_4_reg;
    prod_t            pxg1_reg;
    prod_t            pxg1_next;
    prod_t            pwc1_reg;
    prod_t            pwc1_next;
    word_t            wa2_5_reg;
    word_t            y5_reg;
    word_t            y5_next;
    word_t            wa2_6_reg;
    prod_t            pxg2_reg;
    prod_t            pxg2_next;
    prod_t            pwc2_reg;
    prod_t            pwc2_next;
    word_t            y6_reg;
    word_t            y6_next;
    prod_t            po_reg;
    prod_t            po_next;
    sample_t          out_sample_reg;
    sample_t          out_sample_next;

    // ------------------------------------------------------------------------
    // configuration registers and allpass coefficient 1 - g*g
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comb_gain_reg   <= COMB_GAIN_RST;
            input_gain_reg  <= INPUT_GAIN_RST;
            output_gain_reg <= OUTPUT_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COMB_GAIN:   comb_gain_reg   <= cfg_wdata;
                CFG_INPUT_GAIN:  input_gain_reg  <= cfg_wdata;
                CFG_OUTPUT_GAIN: output_gain_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    assign g_coef       = {1'b0, comb_gain_reg};
    assign gg_prod_next = 32'(comb_gain_reg) * 32'(comb_gain_reg);
    assign gg_round     = 33'(gg_prod_reg) + 33'd32768;
    assign coef_next    = 17'h10000 - gg_round[32:16];

    always_ff @(posedge clk)
    begin
        gg_prod_reg <= gg_prod_next;
        coef_reg    <= coef_next;
    end

    // ------------------------------------------------------------------------
    // clear sweep after reset
    // ------------------------------------------------------------------------
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + PTR_W'(1);
            if (clr_addr_reg == CLR_LAST)
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    assign clr_bus.active = clr_active_reg;
    assign clr_bus.addr   = clr_addr_reg;

    // ------------------------------------------------------------------------
    // elastic pipeline control
    // ------------------------------------------------------------------------
    always_comb
    begin
        go[NSTG+1] = !out_valid_reg || wet.ready;
        for (int k = NSTG; k >= 1; k--)
        begin
            go[k] = !vld_reg[k] || go[k+1];
        end
    end

    // samples not yet written back to every line
    always_comb
    begin
        win_cnt = '0;
        for (int i = 1; i <= WIN; i++)
        begin
            win_cnt = win_cnt + CNT_W'(vld_reg[i]);
        end
    end

    assign dry_ready   = !clr_active_reg && go[1] && (PTR_W'(win_cnt) < TMIN_C);
    assign dry_accept  = dry.valid && dry_ready;
    assign wet_deliver = out_valid_reg && wet.ready;
    assign dry.ready   = dry_ready;

    assign vld_next = (go[NSTG:1] & {vld_reg[NSTG-1:1], dry_accept})
                    | (~go[NSTG:1] & vld_reg);
    assign out_valid_next = go[NSTG+1] ? vld_reg[NSTG] : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign comb_we = vld_reg[2] && go[3];
    assign ap1_we  = vld_reg[4] && go[5];
    assign ap2_we  = vld_reg[6] && go[7];

    // ------------------------------------------------------------------------
    // delay lines
    // ------------------------------------------------------------------------
    for (genvar i = 0; i < 4; i++)
    begin : g_comb
        srv_dline #(
            .WIDTH (WORD_W),
            .DEPTH (COMB_DEPTH[i])
        ) u_line (
            .clk     (clk),
            .rst_n   (rst_n),
            .clr     (clr_bus),
            .rd_en   (dry_accept),
            .rd_data (comb_rd[i]),
            .wr_en   (comb_we),
            .wr_data (cw_next[i])
        );
    end

    assign ap1_wr.x = sum_reg;
    assign ap1_wr.w = wa1_4_reg;
    assign ap2_wr.x = y5_reg;
    assign ap2_wr.w = wa2_6_reg;

    srv_dline #(
        .WIDTH (2 * WORD_W),
        .DEPTH (ALLPASS_DELAY_ONE + 1)
    ) u_ap1_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (clr_bus),
        .rd_en   (dry_accept),
        .rd_data (ap1_rd),
        .wr_en   (ap1_we),
        .wr_data (ap1_wr)
    );

    srv_dline #(
        .WIDTH (2 * WORD_W),
        .DEPTH (ALLPASS_DELAY_TWO + 1)
    ) u_ap2_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (clr_bus),
        .rd_en   (dry_accept),
        .rd_data (ap2_rd),
        .wr_en   (ap2_we),
        .wr_data (ap2_wr)
    );

    // ------------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------------
    always_comb
    begin
        // stage 1: gain products
        px0_next  = srv_mul({{(WORD_W-SAMPLE_W){s1_reg[SAMPLE_W-1]}}, s1_reg},
                            {1'b0, input_gain_reg});
        for (int i = 0; i < 4; i++)
        begin
            pcfb_next[i] = srv_mul(comb_rd[i], g_coef);
        end
        paw1_next = srv_mul(ap1_rd.w, g_coef);
        paw2_next = srv_mul(ap2_rd.w, g_coef);

        // stage 2: comb outputs and allpass states
        x0 = srv_gscale(px0_reg);
        for (int i = 0; i < 4; i++)
        begin
            cw_next[i] = srv_sat24(srv_wide(x0) + srv_wide(srv_gscale(pcfb_reg[i])));
        end
        wa1_3_next = srv_sat24(srv_wide(ax1_reg) + srv_wide(srv_gscale(paw1_reg)));
        wa2_3_next = srv_sat24(srv_wide(ax2_reg) + srv_wide(srv_gscale(paw2_reg)));

        // stage 3: comb sum
        sum_next = srv_sat24(srv_wide(cw_reg[0]) + srv_wide(cw_reg[1])
                           + srv_wide(cw_reg[2]) + srv_wide(cw_reg[3]));

        // stage 4: first allpass products
        pxg1_next = srv_mul(sum_reg, g_coef);
        pwc1_next = srv_mul(wa1_4_reg, coef_reg);

        // stage 5: first allpass output
        y5_next = srv_sat24(srv_wide(srv_gscale(pwc1_reg)) - srv_wide(srv_gscale(pxg1_reg)));

        // stage 6: second allpass products
        pxg2_next = srv_mul(y5_reg, g_coef);
        pwc2_next = srv_mul(wa2_6_reg, coef_reg);

        // stage 7: second allpass output
        y6_next = srv_sat24(srv_wide(srv_gscale(pwc2_reg)) - srv_wide(srv_gscale(pxg2_reg)));

        // stage 8: output gain
        po_next = srv_mul(y6_reg, {1'b0, output_gain_reg});

        // stage 9: round and clamp to 16 bits
        out_sample_next = srv_sat16(srv_gscale(po_reg));
    end

    always_ff @(posedge clk)
    begin
        if (go[1])
        begin
            s1_reg <= dry.in_sample;
        end
        if (go[2])
        begin
            px0_reg  <= px0_next;
            pcfb_reg <= pcfb_next;
            paw1_reg <= paw1_next;
            paw2_reg <= paw2_next;
            ax1_reg  <= ap1_rd.x;
            ax2_reg  <= ap2_rd.x;
        end
        if (go[3])
        begin
            cw_reg    <= cw_next;
            wa1_3_reg <= wa1_3_next;
            wa2_3_reg <= wa2_3_next;
        end
        if (go[4])
        begin
            sum_reg   <= sum_next;
            wa1_4_reg <= wa1_3_reg;
            wa2_4_reg <= wa2_3_reg;
        end
        if (go[5])
        begin
            pxg1_reg  <= pxg1_next;
            pwc1_reg  <= pwc1_next;
            wa2_5_reg <= wa2_4_reg;
        end
        if (go[6])
        begin
            y5_reg    <= y5_next;
            wa2_6_reg <= wa2_5_reg;
        end
        if (go[7])
        begin
            pxg2_reg <= pxg2_next;
            pwc2_reg <= pwc2_next;
        end
        if (go[8])
        begin
            y6_reg <= y6_next;
        end
        if (go[9])
        begin
            po_reg <= po_next;
        end
        if (go[NSTG+1])
        begin
            out_sample_reg <= out_sample_next;
        end
    end

    assign wet.valid      = out_valid_reg;
    assign wet.out_sample = out_sample_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    assert property (@(posedge clk) disable iff (!rst_n)
        !clr_active_reg |=> !clr_active_reg)
        else $error("clear sweep restarted outside reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (!dry_accept && (vld_reg == '0) && !out_valid_reg))
        else $error("pipeline busy during clear sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        PTR_W'(win_cnt) <= TMIN_C)
        else $error("write-back window exceeds shortest delay");

    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones({vld_reg, out_valid_reg})
                  == $past($countones({vld_reg, out_valid_reg}))
                   + int'($past(dry_accept)) - int'($past(wet_deliver))))
        else $error("sample lost or duplicated in pipeline");

endmodule
`default_nettype wire

@@ sv/srv_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srv_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module srv_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1441
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ sv/srv_dline.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srv_dline
// Circular delay line of DEPTH entries on one RAM. The read pointer runs one
// slot ahead of the write pointer, so a read returns the word written
// DEPTH-1 beats earlier. Takes the shared clear sweep after reset.
// ----------------------------------------------------------------------------
module srv_dline #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1441
) (
    input  logic               clk,
    input  logic               rst_n,
    input  srv_pkg::srv_clr_t  clr,
    input  logic               rd_en,
    output logic [WIDTH-1:0]   rd_data,
    input  logic               wr_en,
    input  logic [WIDTH-1:0]   wr_data
);
    import srv_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [PTR_W:0] DEPTH_C = (PTR_W + 1)'(DEPTH);

    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [WIDTH-1:0] ram_wdata;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= AW'(1);
            wr_ptr_reg <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    // zero the line during the clear sweep
    always_comb
    begin
        if (clr.active)
        begin
            ram_we    = ({1'b0, clr.addr} < DEPTH_C);
            ram_waddr = clr.addr[AW-1:0];
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = wr_en;
            ram_waddr = wr_ptr_reg;
            ram_wdata = wr_data;
        end
    end

    srv_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_ptr_reg),
        .rdata (rd_data)
    );

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Streams Q1.15 samples through the reverberator with random gaps on both
// channels and checks every output sample against a bit-true fixed-point
// model of the combs, allpasses and gains. The gain registers are retuned
// between bursts while the block is idle, the saturating and zero settings
// included.
// ----------------------------------------------------------------------------
module testbench;
    import srv_pkg::*;

    localparam int COMB_DELAY_ONE    = 1440;
    localparam int COMB_DELAY_TWO    = 1680;
    localparam int COMB_DELAY_THREE  = 1968;
    localparam int COMB_DELAY_FOUR   = 2112;
    localparam int ALLPASS_DELAY_ONE = 240;
    localparam int ALLPASS_DELAY_TWO = 82;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int MAX_GAP    = 13;
    localparam int PIPE_DRAIN = 12;

    class reverb_tracker;
        gain_t   comb_gain;
        gain_t   input_gain;
        gain_t   output_gain;
        word_t   comb_mem[4][COMB_DELAY_FOUR+1];
        word_t   ap_in[2][ALLPASS_DELAY_ONE+1];
        word_t   ap_state[2][ALLPASS_DELAY_ONE+1];
        int      line_len[6];
        int      wpos[6];
        sample_t wet_expected[$];
        int      mismatches;
        int      checked;

        function new();
            line_len = '{COMB_DELAY_ONE+1, COMB_DELAY_TWO+1, COMB_DELAY_THREE+1,
                         COMB_DELAY_FOUR+1, ALLPASS_DELAY_ONE+1, ALLPASS_DELAY_TWO+1};
            comb_gain   = COMB_GAIN_RST;
            input_gain  = INPUT_GAIN_RST;
            output_gain = OUTPUT_GAIN_RST;
            foreach (comb_mem[k, i]) comb_mem[k][i] = '0;
            foreach (ap_in[k, i]) ap_in[k][i] = '0;
            foreach (ap_state[k, i]) ap_state[k][i] = '0;
            foreach (wpos[k]) wpos[k] = 0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function longint sat24(longint v);
            if (v > 64'sd8388607)
                return 64'sd8388607;
            if (v < -64'sd8388608)
                return -64'sd8388608;
            return v;
        endfunction

        // round half up, drop 16 fraction bits
        function longint scale(longint a, longint g);
            longint p;
            p = a * g + 64'sd32768;
            return sat24(p >>> 16);
        endfunction

        function int tap(int k);
            int r;
            r = wpos[k] + 1;
            if (r >= line_len[k])
                r = 0;
            return r;
        endfunction

        function void configure(logic [CFG_IDX_W-1:0] idx, gain_t value);
            case (idx)
                CFG_COMB_GAIN:   comb_gain   = value;
                CFG_INPUT_GAIN:  input_gain  = value;
                CFG_OUTPUT_GAIN: output_gain = value;
                default: ;
            endcase
        endfunction

        function void take_sample(sample_t s);
            longint c;
            longint x;
            longint w;
            longint y;
            longint acc;
            longint o;
            int     k;
            c   = 65536 - ((longint'(comb_gain) * longint'(comb_gain) + 32768) >>> 16);
            x   = scale(s, input_gain);
            acc = 0;
            for (int j = 0; j < 4; j++)
            begin
                w = sat24(x + scale(comb_mem[j][tap(j)], comb_gain));
                comb_mem[j][wpos[j]] = word_t'(w);
                wpos[j] = tap(j);
                acc += w;
            end
            y = sat24(acc);
            for (int j = 0; j < 2; j++)
            begin
                k = 4 + j;
                w = sat24(ap_in[j][tap(k)] + scale(ap_state[j][tap(k)], comb_gain));
                ap_in[j][wpos[k]]    = word_t'(y);
                ap_state[j][wpos[k]] = word_t'(w);
                wpos[k] = tap(k);
                y = sat24(scale(w, c) - scale(y, comb_gain));
            end
            o = scale(y, output_gain);
            if (o > 32767)
                o = 32767;
            if (o < -32768)
                o = -32768;
            wet_expected.push_back(sample_t'(o));
        endfunction

        function void check_sample(sample_t got);
            sample_t want;
            if (wet_expected.size() == 0)
            begin
                $error("out_sample: expected none pending, got %0d", got);
                mismatches++;
                return;
            end
            want = wet_expected.pop_front();
            checked++;
            if (got !== want)
            begin
                $error("out_sample: expected %0d, got %0d", want, got);
                mismatches++;
            end
        endfunction

        function int pending();
            return wet_expected.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    gain_t                cfg_wdata;

    srv_in_if  dry_ch();
    srv_out_if wet_ch();

    reverb_tracker tracker = new();

    int sent;
    int settings;
    bit src_steady;
    bit sink_steady;

    schroeder_reverb #(
        .COMB_DELAY_ONE    (COMB_DELAY_ONE),
        .COMB_DELAY_TWO    (COMB_DELAY_TWO),
        .COMB_DELAY_THREE  (COMB_DELAY_THREE),
        .COMB_DELAY_FOUR   (COMB_DELAY_FOUR),
        .ALLPASS_DELAY_ONE (ALLPASS_DELAY_ONE),
        .ALLPASS_DELAY_TWO (ALLPASS_DELAY_TWO)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .dry       (dry_ch),
        .wet       (wet_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function int draw_gap(bit steady);
        if (steady)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function sample_t draw_sample();
        int v;
        case ($urandom_range(0, 9))
            0:       v = 32767;
            1:       v = -32768;
            2, 3:    v = int'($urandom_range(0, 511)) - 256;
            default: v = $urandom;
        endcase
        return sample_t'(v);
    endfunction

    function gain_t draw_gain();
        return gain_t'($urandom_range(0, 65535));
    endfunction

    task automatic send_sample(input sample_t s);
        int gap;
        gap = draw_gap(src_steady);
        @(negedge clk);
        if (gap > 0)
        begin
            dry_ch.valid     <= 1'b0;
            dry_ch.in_sample <= sample_t'($urandom);
            repeat (gap) @(negedge clk);
        end
        dry_ch.valid     <= 1'b1;
        dry_ch.in_sample <= s;
        do @(posedge clk); while (dry_ch.ready !== 1'b1);
        tracker.take_sample(s);
        sent++;
        if (sent % 40 == 0)
            src_steady = ($urandom_range(0, 3) == 0);
    endtask

    task automatic stream(input int count);
        repeat (count) send_sample(draw_sample());
    endtask

    // drop valid and drain the pipeline
    task automatic settle();
        @(negedge clk);
        dry_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (PIPE_DRAIN) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input gain_t value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        tracker.configure(idx, value);
    endtask

    task automatic retune(input gain_t g_comb, input gain_t g_in, input gain_t g_out);
        settle();
        write_reg(CFG_COMB_GAIN, g_comb);
        write_reg(CFG_INPUT_GAIN, g_in);
        write_reg(CFG_OUTPUT_GAIN, g_out);
        settings++;
    endtask

    initial
    begin : wet_sink
        int gap;
        int taken;
        wet_ch.ready = 1'b0;
        taken = 0;
        forever
        begin
            gap = draw_gap(sink_steady);
            @(negedge clk);
            if (gap > 0)
            begin
                wet_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            wet_ch.ready <= 1'b1;
            do @(posedge clk); while (wet_ch.valid !== 1'b1);
            tracker.check_sample(wet_ch.out_sample);
            taken++;
            if (taken % 40 == 0)
                sink_steady = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin : stimulus
        sample_t corner[$];
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_COMB_GAIN;
        cfg_wdata        = '0;
        dry_ch.valid     = 1'b0;
        dry_ch.in_sample = '0;
        sent             = 0;
        settings         = 1;
        src_steady       = 1'b0;
        sink_steady      = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        corner = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff,
                   16'sh5555, 16'shaaaa, 16'sh7fff, 16'sh8000, 16'sh7fff,
                   16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
                   16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
                   16'sh8000, 16'sh0000};
        foreach (corner[i]) send_sample(corner[i]);
        stream(180);

        retune(draw_gain(), draw_gain(), draw_gain());
        stream(150);
        retune(16'hffff, 16'hffff, 16'hffff);
        stream(200);
        retune(draw_gain(), draw_gain(), draw_gain());
        stream(150);
        retune(16'h0000, 16'h0000, 16'h0000);
        write_reg(CFG_UNUSED, draw_gain());
        stream(100);
        retune(16'h0000, 16'hffff, 16'hffff);
        stream(100);

        settle();
        repeat (20) @(posedge clk);
        $display("Streamed %0d samples under %0d gain settings, %0d outputs checked.",
                 sent, settings, tracker.checked);
        $display("Settings ranged over reset, saturating, zero and random gains.");
        if (tracker.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #(5_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
sv/srv_pkg.sv
sv/srv_in_if.sv
sv/srv_out_if.sv
sv/srv_ram.sv
sv/srv_dline.sv
sv/schroeder_reverb.sv
test/testbench.sv
